@@ sv/mm5x5_pkg.sv @@
// ----------------------------------------------------------------------------
// mm5x5_pkg
// Shared types and codes for the square matrix multiplier and its MAC cells.
// ----------------------------------------------------------------------------
package mm5x5_pkg;

	// default matrix dimension
	localparam int DIM_DEF = 5;

	// field widths of the input and result words
	localparam int OP_W    = 2;
	localparam int FIELD_W = 3;
	localparam int VAL_W   = 16;
	localparam int PROD_W  = 34;
	localparam int IN_W    = 24;
	localparam int OUT_W   = 40;

	// operation codes
	localparam logic [OP_W-1:0] OP_LOAD_A  = 2'd0;
	localparam logic [OP_W-1:0] OP_LOAD_B  = 2'd1;
	localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

	typedef logic signed [VAL_W-1:0]  val_t;
	typedef logic signed [PROD_W-1:0] prod_t;

	// one element of A travelling down the cell chain
	typedef struct packed {
		logic               valid;
		logic               first;
		logic               last;
		logic [FIELD_W-1:0] k;
		val_t               value;
	} tok_t;

	// control broadcast to all cells: B write port and result shift
	typedef struct packed {
		logic               b_we;
		logic [FIELD_W-1:0] b_row;
		logic [FIELD_W-1:0] b_col;
		val_t               b_value;
		logic               shift;
	} ctl_t;

endpackage

@@ sv/matrix_multiply_5x5.sv @@
// ----------------------------------------------------------------------------
// matrix_multiply_5x5
// Square signed matrix multiplier built from a chain of DIM MAC cells.
// ----------------------------------------------------------------------------
// Channel  Dir  Signals                      Word
// s_axis   in   tvalid tready tdata[23:0]   load A / load B / compute
// m_axis   out  tvalid tready tdata[39:0]   one product element, tlast on final
//                  tlast
//
// A load word with row and col below DIM is written when taken. A compute word
// runs row by row: row i of A is streamed into the chain, the sequencer waits
// until the last cell has its sum, then DIM words go out.
// No word is taken while a compute is in progress. Output stalls hold the
// current word and freeze the result shift. Reset clears control state only.
// ----------------------------------------------------------------------------
module matrix_multiply_5x5 #(
	parameter int DIM = mm5x5_pkg::DIM_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// operation[1:0], row[4:2], col[7:5], element_value[23:8]
	input  logic [mm5x5_pkg::IN_W-1:0]    s_axis_tdata,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// out_row[2:0], out_col[5:3], product_value[39:6]
	output logic [mm5x5_pkg::OUT_W-1:0]   m_axis_tdata,
	output logic                          m_axis_tlast,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready
);
	import mm5x5_pkg::*;

	localparam int KW = (DIM > 1) ? $clog2(DIM) : 1;
	localparam int AW = $clog2(DIM * DIM);
	localparam logic [KW-1:0]      KLAST   = KW'(DIM - 1);
	localparam logic [FIELD_W:0]   DIM_LIM = (FIELD_W + 1)'(DIM);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FEED,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	state_t               state_q;
	logic [AW-1:0]        addr_q;
	logic [KW-1:0]        k_q;
	logic [KW-1:0]        row_q;
	logic [KW-1:0]        col_q;
	logic                 tag_vld_s1;
	logic                 tag_first_s1;
	logic                 tag_last_s1;
	logic [FIELD_W-1:0]   tag_k_s1;
	val_t                 a_rd_s1;
	val_t                 a_mem [DIM*DIM];

	logic [OP_W-1:0]      in_op;
	logic [FIELD_W-1:0]   in_row;
	logic [FIELD_W-1:0]   in_col;
	val_t                 in_val;
	logic                 in_acc;
	logic                 out_acc;
	logic                 ld_ok;
	logic                 a_we;
	logic [AW-1:0]        ld_addr;

	ctl_t                 ctl;
	tok_t                 tok   [DIM+1];
	prod_t                res   [DIM+1];
	logic [DIM-1:0]       done_w;

	// unpack input word
	assign in_op  = s_axis_tdata[1:0];
	assign in_row = s_axis_tdata[4:2];
	assign in_col = s_axis_tdata[7:5];
	assign in_val = s_axis_tdata[23:8];

	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;
	assign ld_ok   = ({1'b0, in_row} < DIM_LIM) && ({1'b0, in_col} < DIM_LIM);
	assign a_we    = in_acc && in_op == OP_LOAD_A && ld_ok;
	assign ld_addr = AW'(int'(in_row) * DIM + int'(in_col));

	// A store, row-major, registered read at the feed address
	always_ff @(posedge clk) begin
		if (a_we) begin
			a_mem[ld_addr] <= in_val;
		end
		a_rd_s1 <= a_mem[addr_q];
	end

	// broadcast control to the cells
	always_comb begin
		ctl.b_we    = in_acc && in_op == OP_LOAD_B && ld_ok;
		ctl.b_row   = in_row;
		ctl.b_col   = in_col;
		ctl.b_value = in_val;
		ctl.shift   = out_acc;
	end

	// sequencer: feed a row, wait for the chain, emit the row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			addr_q       <= '0;
			k_q          <= '0;
			row_q        <= '0;
			col_q        <= '0;
			tag_vld_s1   <= 1'b0;
			tag_first_s1 <= 1'b0;
			tag_last_s1  <= 1'b0;
			tag_k_s1     <= '0;
		end else begin
			tag_vld_s1 <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && in_op == OP_COMPUTE) begin
						state_q <= ST_FEED;
						addr_q  <= '0;
						k_q     <= '0;
						row_q   <= '0;
						col_q   <= '0;
					end
				end
				ST_FEED: begin
					tag_vld_s1   <= 1'b1;
					tag_first_s1 <= (k_q == '0);
					tag_last_s1  <= (k_q == KLAST);
					tag_k_s1     <= FIELD_W'(k_q);
					addr_q       <= addr_q + 1'b1;
					if (k_q == KLAST) begin
						k_q     <= '0;
						state_q <= ST_DRAIN;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (done_w[DIM-1]) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_acc) begin
						if (col_q == KLAST) begin
							col_q <= '0;
							if (row_q == KLAST) begin
								state_q <= ST_IDLE;
							end else begin
								row_q   <= row_q + 1'b1;
								state_q <= ST_FEED;
							end
						end else begin
							col_q <= col_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// head of the chain: tag plus the A element read from the store
	always_comb begin
		tok[0].valid = tag_vld_s1;
		tok[0].first = tag_first_s1;
		tok[0].last  = tag_last_s1;
		tok[0].k     = tag_k_s1;
		tok[0].value = a_rd_s1;
	end

	// nothing shifts into the far end of the result chain
	assign res[DIM] = '0;

	// cell chain, cell j owns column j of B and of the product
	for (genvar j = 0; j < DIM; j++) begin : g_cell
		mm5x5_cell #(
			.DIM (DIM),
			.IDX (j)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.tok_in  (tok[j]),
			.tok_out (tok[j+1]),
			.res_in  (res[j+1]),
			.res_out (res[j]),
			.done    (done_w[j])
		);
	end

	// output word
	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = (state_q == ST_EMIT);
	assign m_axis_tdata  = {res[0], FIELD_W'(col_q), FIELD_W'(row_q)};
	assign m_axis_tlast  = (row_q == KLAST) && (col_q == KLAST);

	// checks
	ast_no_accept_while_emit: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("input taken while a product word is pending");

	ast_one_cell_done: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(done_w))
		else $error("more than one cell finished in the same cycle");

	ast_done_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		done_w[DIM-1] |-> state_q == ST_DRAIN)
		else $error("last cell finished outside the drain phase");

	ast_ready_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
		else $error("not ready after the final product word");

endmodule

@@ sv/mm5x5_cell.sv @@
// ----------------------------------------------------------------------------
// mm5x5_cell
// One MAC cell of the chain. Holds one column of B, multiplies each passing
// A element by the matching B entry and accumulates one product element.
// Finished sums shift toward cell 0 through the result chain.
// ----------------------------------------------------------------------------
module mm5x5_cell #(
	parameter int DIM = mm5x5_pkg::DIM_DEF,
	parameter int IDX = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  mm5x5_pkg::ctl_t    ctl,
	input  mm5x5_pkg::tok_t    tok_in,
	output mm5x5_pkg::tok_t    tok_out,
	input  mm5x5_pkg::prod_t   res_in,
	output mm5x5_pkg::prod_t   res_out,
	output logic               done
);
	import mm5x5_pkg::*;

	localparam int KW = (DIM > 1) ? $clog2(DIM) : 1;
	localparam logic [FIELD_W-1:0] COL_ID = FIELD_W'(IDX);

	val_t                     b_col [DIM];
	tok_t                     tok_q;
	logic                     vld_s1;
	logic                     first_s1;
	logic                     last_s1;
	logic signed [2*VAL_W-1:0] prod_s1;
	prod_t                    acc_q;
	prod_t                    res_q;
	prod_t                    acc_base;
	prod_t                    acc_nxt;

	// column store of B, written when the load targets this column
	always_ff @(posedge clk) begin
		if (ctl.b_we && ctl.b_col == COL_ID) begin
			b_col[ctl.b_row[KW-1:0]] <= ctl.b_value;
		end
	end

	// token register, passed on to the neighbor every cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_in;
		end
	end

	// multiply stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			first_s1 <= 1'b0;
			last_s1  <= 1'b0;
		end else begin
			vld_s1   <= tok_q.valid;
			first_s1 <= tok_q.first;
			last_s1  <= tok_q.last;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= tok_q.value * b_col[tok_q.k[KW-1:0]];
	end

	// accumulate, restarting on the first term of each element
	assign acc_base = first_s1 ? '0 : acc_q;
	assign acc_nxt  = acc_base + {{(PROD_W-2*VAL_W){prod_s1[2*VAL_W-1]}}, prod_s1};

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			acc_q <= acc_nxt;
		end
	end

	// result register: loaded on the last term, shifted toward cell 0 on emit
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			res_q <= res_in;
		end else if (vld_s1 && last_s1) begin
			res_q <= acc_nxt;
		end
	end

	assign done    = vld_s1 & last_s1;
	assign tok_out = tok_q;
	assign res_out = res_q;

endmodule
